[sv/ict_pkg.sv]
// Shared constants, the power-of-three maximum table and helpers for the integer complexity table.
package ict_pkg;

    // width of one table value and the "not yet found" mark
    localparam int VAL_W = 7;
    localparam logic [VAL_W-1:0] UNKNOWN_F = 7'd127;

    // configuration register
    localparam int CFG_W = 17;
    localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 17'd65536;
    localparam logic REG_TABLE_SIZE_IDX = 1'b0;

    // power-of-three maximum g(k), saturated at 2^40
    localparam int G_W     = 41;
    localparam int G_DEPTH = 128;
    localparam logic [G_W+2:0] G_SAT = (G_W+3)'(1) << (G_W - 1);

    typedef logic [G_W-1:0] t_g_rom [G_DEPTH];

    function automatic t_g_rom build_g_rom();
        t_g_rom         rom;
        logic [G_W+2:0] p3 [G_DEPTH/3+1];
        logic [G_W+2:0] v;
        int             q;
        int             r;
        p3[0] = (G_W+3)'(1);
        for (int j = 1; j < G_DEPTH/3+1; j++) begin
            v     = p3[j-1] * (G_W+3)'(3);
            p3[j] = (v >= G_SAT) ? G_SAT : v;
        end
        q = 0;
        r = 0;
        for (int k = 0; k < G_DEPTH; k++) begin
            if (k <= 1) begin
                rom[k] = G_W'(1);
            end else begin
                case (r)
                    0:       v = p3[q];
                    1:       v = p3[q-1] * (G_W+3)'(4);
                    default: v = p3[q] * (G_W+3)'(2);
                endcase
                rom[k] = (v > G_SAT) ? G_SAT[G_W-1:0] : v[G_W-1:0];
            end
            r = r + 1;
            if (r == 3) begin
                r = 0;
                q = q + 1;
            end
        end
        return rom;
    endfunction

    localparam t_g_rom G_ROM = build_g_rom();

endpackage

[sv/ict_bound.sv]
// Split bound search: lowers k one step a cycle against the power-of-three maximum.
module ict_bound #(
    parameter int N_W = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ict_pkg::VAL_W-1:0]  i_prev,
    input  logic [N_W-1:0]             i_n,
    output logic                       o_done,
    output logic [N_W-1:0]             o_lim
);

    logic                         r_busy;
    logic                         r_done;
    logic [ict_pkg::VAL_W-2:0]    r_k;
    logic [ict_pkg::VAL_W-1:0]    r_prev;
    logic [N_W-1:0]               r_n;
    logic [N_W-1:0]               r_lim;

    logic [ict_pkg::G_W-1:0]      w_gk;
    logic [ict_pkg::G_W-1:0]      w_gr;
    logic [ict_pkg::G_W:0]        w_gsum;
    logic                         w_lower;
    logic [N_W-1:0]               w_nm1;
    logic                         w_cap;

    // one wide add and compare per step
    assign w_gk    = ict_pkg::G_ROM[{1'b0, r_k}];
    assign w_gr    = ict_pkg::G_ROM[r_prev - {1'b0, r_k}];
    assign w_gsum  = {1'b0, w_gk} + {1'b0, w_gr};
    assign w_lower = (r_k != '0) && (w_gsum < (ict_pkg::G_W+1)'(r_n));
    assign w_nm1   = r_n - N_W'(1);
    assign w_cap   = w_gk > ict_pkg::G_W'(w_nm1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= i_prev[ict_pkg::VAL_W-1:1];
                r_prev <= i_prev;
                r_n    <= i_n;
            end else if (r_busy) begin
                if (w_lower) begin
                    r_k <= r_k - (ict_pkg::VAL_W-1)'(1);
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_lim  <= w_cap ? w_nm1 : w_gk[N_W-1:0];
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_lim  = r_lim;

endmodule

[sv/integer_complexity_table.sv]
// Integer complexity table: sequencer, 2R1W value memory and APB register.
// Per item: b split bound steps (at most 63), L additive splits (bound, capped
// at n-1) and m multiplicative updates (i*n below size); each split and each update
// is one memory read pair. One item in flight at a time. Exhausted items skip
// the search and go straight to output. Reset and every restart run a clearing pass
// over all MAX_ENTRIES memory entries, during which no item is taken.
module integer_complexity_table #(
    parameter int MAX_ENTRIES = 65536
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_restart,
    // output channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [15:0]                o_index,
    output logic [ict_pkg::VAL_W-1:0]  o_complexity,
    output logic                       o_exhausted,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int AW = $clog2(MAX_ENTRIES);   // memory address
    localparam int NW = AW + 1;                // index incl. the size itself
    localparam int TW = AW + 2;                // product i*n, may pass the size once
    localparam int SW = (NW > ict_pkg::CFG_W) ? NW : ict_pkg::CFG_W;
    localparam int VW = ict_pkg::VAL_W;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b00_0000_0001,
        S_IDLE  = 10'b00_0000_0010,
        S_CHECK = 10'b00_0000_0100,
        S_READ  = 10'b00_0000_1000,
        S_LOAD  = 10'b00_0001_0000,
        S_BOUND = 10'b00_0010_0000,
        S_ADD   = 10'b00_0100_0000,
        S_WRN   = 10'b00_1000_0000,
        S_MUL   = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } t_state;

    // ---------------------------------------------------------------- registers
    t_state             r_state,    n_state;
    logic [AW-1:0]      r_clr_addr, n_clr_addr;
    logic               r_clr_run,  n_clr_run;   // clearing pass belongs to a restart
    logic [AW-1:0]      r_cur,      n_cur;       // last index computed
    logic [AW-1:0]      r_n,        n_n;         // index being worked on
    logic [VW-1:0]      r_fn,       n_fn;        // running f(n)
    logic [NW-1:0]      r_i,        n_i;         // loop counter, both passes
    logic [TW-1:0]      r_t,        n_t;         // n-i in the additive pass, i*n after
    logic               r_pv,       n_pv;        // memory read in flight
    logic [AW-1:0]      r_pt,       n_pt;        // write target of that read
    logic               r_exh,      n_exh;
    logic               r_ov,       n_ov;
    logic [15:0]        r_o_index,  n_o_index;
    logic [VW-1:0]      r_o_cplx,   n_o_cplx;
    logic               r_o_exh,    n_o_exh;
    logic [ict_pkg::CFG_W-1:0] r_table_size;

    // value memory, two read ports and one write port, registered reads
    logic [VW-1:0]      r_mem [MAX_ENTRIES];
    logic [VW-1:0]      r_rda;
    logic [VW-1:0]      r_rdb;

    // ---------------------------------------------------------------- wires
    logic               w_we;
    logic [AW-1:0]      w_wa;
    logic [VW-1:0]      w_wd;
    logic [AW-1:0]      w_ra;
    logic [AW-1:0]      w_rb;
    logic               w_in_xfer;
    logic               w_out_free;
    logic [NW-1:0]      w_n_next;
    logic [SW-1:0]      w_ts_ext;
    logic [SW-1:0]      w_size_ext;
    logic [NW-1:0]      w_size;
    logic [TW-1:0]      w_t_step;
    logic [VW:0]        w_cand_add;
    logic [VW:0]        w_cand_mul;
    logic               w_issue;
    logic               w_bnd_start;
    logic               w_bnd_done;
    logic [AW-1:0]      w_bnd_lim;
    logic               w_cfg_wr;

    // size in use: table_size clamped to [2, MAX_ENTRIES]
    assign w_ts_ext   = SW'(r_table_size);
    assign w_size_ext = (w_ts_ext < SW'(2))           ? SW'(2) :
                        (w_ts_ext > SW'(MAX_ENTRIES)) ? SW'(MAX_ENTRIES) : w_ts_ext;
    assign w_size     = w_size_ext[NW-1:0];

    assign w_n_next   = NW'(r_cur) + NW'(1);

    // the one shared adder: steps n-i down in the additive pass, i*n up by n after
    assign w_t_step   = r_t + ((r_state == S_MUL) ? TW'(r_n) : {TW{1'b1}});

    assign w_cand_add = (VW+1)'(r_rda) + (VW+1)'(r_rdb);
    assign w_cand_mul = (VW+1)'(r_rda) + (VW+1)'(r_fn);

    assign w_in_xfer  = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_ov || !i_out_stall;

    // ---------------------------------------------------------------- split bound unit
    ict_bound #(
        .N_W (AW)
    ) u_bound (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_bnd_start),
        .i_prev  (r_rda),
        .i_n     (r_n),
        .o_done  (w_bnd_done),
        .o_lim   (w_bnd_lim)
    );

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_clr_run   = r_clr_run;
        n_cur       = r_cur;
        n_n         = r_n;
        n_fn        = r_fn;
        n_i         = r_i;
        n_t         = r_t;
        n_pv        = 1'b0;
        n_pt        = r_pt;
        n_exh       = r_exh;
        n_ov        = r_ov && i_out_stall;
        n_o_index   = r_o_index;
        n_o_cplx    = r_o_cplx;
        n_o_exh     = r_o_exh;
        w_we        = 1'b0;
        w_wa        = r_clr_addr;
        w_wd        = ict_pkg::UNKNOWN_F;
        w_ra        = r_n - AW'(1);
        w_rb        = r_n;
        w_bnd_start = 1'b0;
        w_issue     = 1'b0;

        unique case (r_state)
            // one entry a cycle: 0 at index 0, 1 at index 1, unknown elsewhere
            S_CLEAR: begin
                w_we = 1'b1;
                if (r_clr_addr == AW'(0)) begin
                    w_wd = VW'(0);
                end else if (r_clr_addr == AW'(1)) begin
                    w_wd = VW'(1);
                end
                if (r_clr_addr == AW'(MAX_ENTRIES - 1)) begin
                    n_cur   = '0;
                    n_state = r_clr_run ? S_CHECK : S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + AW'(1);
                end
            end
            S_IDLE: begin
                if (w_in_xfer) begin
                    if (i_restart) begin
                        n_clr_addr = '0;
                        n_clr_run  = 1'b1;
                        n_state    = S_CLEAR;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (w_n_next >= w_size) begin
                    n_exh   = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_exh   = 1'b0;
                    n_n     = w_n_next[AW-1:0];
                    n_state = S_READ;
                end
            end
            // fetch f(n-1) on port a, f(n) on port b
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_fn        = r_rdb;
                w_bnd_start = 1'b1;
                n_i         = NW'(1);
                n_t         = TW'(r_n) - TW'(1);
                n_state     = S_BOUND;
            end
            S_BOUND: begin
                if (w_bnd_done) begin
                    n_state = S_ADD;
                end
            end
            // splits f(i) + f(n-i), one read pair issued per cycle
            S_ADD: begin
                w_issue = r_i <= NW'(w_bnd_lim);
                w_ra    = r_i[AW-1:0];
                w_rb    = r_t[AW-1:0];
                if (w_issue) begin
                    n_pv = 1'b1;
                    n_i  = r_i + NW'(1);
                    n_t  = w_t_step;
                end
                if (r_pv && (w_cand_add < (VW+1)'(r_fn))) begin
                    n_fn = w_cand_add[VW-1:0];
                end
                if (!w_issue && !r_pv) begin
                    n_state = S_WRN;
                end
            end
            S_WRN: begin
                w_we    = 1'b1;
                w_wa    = r_n;
                w_wd    = r_fn;
                n_cur   = r_n;
                n_i     = NW'(2);
                n_t     = {TW'(r_n)} << 1;
                n_state = S_MUL;
            end
            // push f(i) + f(n) into entry i*n; targets all lie above n
            S_MUL: begin
                w_issue = (r_i <= NW'(r_n)) && (r_t < TW'(w_size));
                w_ra    = r_i[AW-1:0];
                w_rb    = r_t[AW-1:0];
                if (w_issue) begin
                    n_pv = 1'b1;
                    n_pt = r_t[AW-1:0];
                    n_i  = r_i + NW'(1);
                    n_t  = w_t_step;
                end
                if (r_pv && (w_cand_mul < (VW+1)'(r_rdb))) begin
                    w_we = 1'b1;
                    w_wa = r_pt;
                    w_wd = w_cand_mul[VW-1:0];
                end
                if (!w_issue && !r_pv) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_ov      = 1'b1;
                    n_o_exh   = r_exh;
                    n_o_index = r_exh ? 16'd0 : 16'(r_n);
                    n_o_cplx  = r_exh ? VW'(0) : r_fn;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_clr_run  <= 1'b0;
            r_cur      <= '0;
            r_pv       <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_clr_run  <= n_clr_run;
            r_cur      <= n_cur;
            r_pv       <= n_pv;
            r_ov       <= n_ov;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_fn      <= n_fn;
        r_i       <= n_i;
        r_t       <= n_t;
        r_pt      <= n_pt;
        r_exh     <= n_exh;
        r_o_index <= n_o_index;
        r_o_cplx  <= n_o_cplx;
        r_o_exh   <= n_o_exh;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rda <= r_mem[w_ra];
        r_rdb <= r_mem[w_rb];
    end

    // ---------------------------------------------------------------- APB register
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == ict_pkg::REG_TABLE_SIZE_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= ict_pkg::TABLE_SIZE_RESET;
        end else if (w_cfg_wr) begin
            r_table_size <= pwdata[ict_pkg::CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == ict_pkg::REG_TABLE_SIZE_IDX) ? 32'(r_table_size) : 32'd0;
    assign pready = 1'b1;

    // ---------------------------------------------------------------- outputs
    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_ov;
    assign o_index      = r_o_index;
    assign o_complexity = r_o_cplx;
    assign o_exhausted  = r_o_exh;

    // ---------------------------------------------------------------- assertions
    // the table is never written while waiting for a transfer
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_we)
        else $error("memory write while idle");

    // multiplicative updates only land above the current index
    a_mul_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && w_we) |-> (r_pt > r_n))
        else $error("multiplicative update at or below n");

    // a new result is only loaded from the output state
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == S_OUT))
        else $error("result appeared outside the output state");

    // the bound unit reports only while the sequencer waits for it
    a_bound_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bnd_done |-> (r_state == S_BOUND))
        else $error("split bound finished out of sequence");

endmodule
